FILE: hdl/srsw_pkg.sv
// shared types and constants for the selective-repeat sender window
// no dependencies; used by srsw_cell, selective_repeat_sender_window, the checkers and tb_top
package srsw_pkg;

  // sequence numbers are fixed at three bits, so the sequence space is eight
  localparam int SEQ_W     = 3;
  localparam int SEQ_SPACE = 1 << SEQ_W;

  // event codes on the operation field
  localparam logic [1:0] OP_SEND    = 2'd0;
  localparam logic [1:0] OP_ACK     = 2'd1;
  localparam logic [1:0] OP_TIMEOUT = 2'd2;

  // reset value of base and next sequence
  localparam logic [SEQ_W-1:0] SEQ_RESET = SEQ_W'(1);

  // broadcast control to every mark cell
  typedef struct packed {
    logic shift;  // take the right neighbor's mark
    logic set;    // mark the cell addressed by idx
    logic clr;    // clear the cell addressed by idx
  } cell_ctl_t;

endpackage

FILE: hdl/srsw_cell.sv
// one window slot: holds the acknowledged mark of its slot
// depends on srsw_pkg (cell_ctl_t); chained by selective_repeat_sender_window
module srsw_cell #(
  parameter int IDX_W = 2,
  parameter int IDX   = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  srsw_pkg::cell_ctl_t   ctl,
  input  logic [IDX_W-1:0]      idx,
  input  logic                  right_mark,
  output logic                  mark
);

  logic mark_r;
  logic mark_nxt;
  logic hit;

  // address decode for set and clear
  assign hit = (idx == IDX_W'(IDX));

  // shift wins; set and clear only touch the addressed slot
  always_comb begin
    mark_nxt = mark_r;
    if (ctl.shift) begin
      mark_nxt = right_mark;
    end else if (ctl.set && hit) begin
      mark_nxt = 1'b1;
    end else if (ctl.clr && hit) begin
      mark_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r <= 1'b0;
    end else begin
      mark_r <= mark_nxt;
    end
  end

  assign mark = mark_r;

endmodule

FILE: hdl/selective_repeat_sender_window.sv
// result path: sends, timeouts and acks off the base load the result register from the idle state,
//   or through the wait state while the result side stalls; an ack at the base first passes the
//   slide state, where the mark chain moves one slot per cycle past each leading acknowledged slot
// throughput: one item per cycle while no slide runs and the result side keeps up
// reset (rst_n low, synchronous): base and next sequence 1, no packets outstanding,
//   all marks clear, no result pending
module selective_repeat_sender_window #(
  parameter int WINDOW = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [srsw_pkg::SEQ_W-1:0]  in_seq_number,
  input  logic                        in_checksum_ok,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_send_accepted,
  output logic                        out_transmit,
  output logic [srsw_pkg::SEQ_W-1:0]  out_transmit_seq,
  output logic                        out_start_timer,
  output logic                        out_stop_timer,
  output logic [srsw_pkg::SEQ_W-1:0]  out_timer_seq,
  output logic                        out_window_full,
  output logic [srsw_pkg::SEQ_W-1:0]  out_window_base
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CMP_W = (CNT_W > srsw_pkg::SEQ_W) ? CNT_W : srsw_pkg::SEQ_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SLIDE,
    ST_WAIT
  } state_t;

  typedef struct packed {
    logic                       send_accepted;
    logic                       transmit;
    logic [srsw_pkg::SEQ_W-1:0] transmit_seq;
    logic                       start_timer;
    logic                       stop_timer;
    logic [srsw_pkg::SEQ_W-1:0] timer_seq;
  } res_t;

  state_t                     state_r, state_nxt;
  logic [srsw_pkg::SEQ_W-1:0] base_r, base_nxt;
  logic [srsw_pkg::SEQ_W-1:0] next_r, next_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  res_t                       pend_r, pend_nxt;
  res_t                       res_now, load_res;
  logic                       load;

  logic                       out_valid_r;
  res_t                       out_res_r;
  logic                       out_full_r;
  logic [srsw_pkg::SEQ_W-1:0] out_base_r;

  srsw_pkg::cell_ctl_t        ctl;
  logic [IDX_W-1:0]           ctl_idx;
  logic [WINDOW-1:0]          marks;
  logic [WINDOW-1:0]          right_w;

  logic                       in_xfer;
  logic                       out_free;
  logic [srsw_pkg::SEQ_W-1:0] off;
  logic [IDX_W-1:0]           off_idx;
  logic                       in_win;
  logic                       off_mark;
  logic                       can_send;

  // handshake
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  // modular distance from base; the sequence space is a power of two
  assign off      = in_seq_number - base_r;
  assign off_idx  = IDX_W'(off);
  assign in_win   = CMP_W'(off) < CMP_W'(cnt_r);
  assign off_mark = in_win && marks[off_idx];
  assign can_send = cnt_r < CNT_W'(WINDOW);

  // result fields of the event, before any slide
  always_comb begin
    res_now = '0;
    case (in_operation)
      srsw_pkg::OP_SEND: begin
        if (can_send) begin
          res_now.send_accepted = 1'b1;
          res_now.transmit      = 1'b1;
          res_now.transmit_seq  = next_r;
          res_now.start_timer   = 1'b1;
          res_now.timer_seq     = next_r;
        end
      end
      srsw_pkg::OP_ACK: begin
        if (in_checksum_ok && in_win) begin
          res_now.stop_timer = 1'b1;
          res_now.timer_seq  = in_seq_number;
        end
      end
      srsw_pkg::OP_TIMEOUT: begin
        if (in_win && !off_mark) begin
          res_now.transmit     = 1'b1;
          res_now.transmit_seq = in_seq_number;
          res_now.start_timer  = 1'b1;
          res_now.timer_seq    = in_seq_number;
        end
      end
      default: begin
        res_now = '0;
      end
    endcase
  end

  // window control and sequencing
  always_comb begin
    state_nxt = state_r;
    base_nxt  = base_r;
    next_nxt  = next_r;
    cnt_nxt   = cnt_r;
    pend_nxt  = pend_r;
    load      = 1'b0;
    load_res  = pend_r;
    ctl       = '0;
    ctl_idx   = off_idx;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          // per-event updates of count, next sequence and marks
          if (in_operation == srsw_pkg::OP_SEND && can_send) begin
            ctl.clr  = 1'b1;
            ctl_idx  = IDX_W'(cnt_r);
            cnt_nxt  = cnt_r + CNT_W'(1);
            next_nxt = next_r + srsw_pkg::SEQ_W'(1);
          end else if (in_operation == srsw_pkg::OP_ACK && in_checksum_ok && in_win) begin
            ctl.set = 1'b1;
          end
          // an ack at the base starts a slide; otherwise the result loads now, or waits while the result side stalls
          if (in_operation == srsw_pkg::OP_ACK && in_checksum_ok && in_win &&
              off == '0) begin
            pend_nxt  = res_now;
            state_nxt = ST_SLIDE;
          end else if (out_free) begin
            load     = 1'b1;
            load_res = res_now;
          end else begin
            pend_nxt  = res_now;
            state_nxt = ST_WAIT;
          end
        end
      end
      ST_SLIDE: begin
        // one slot per cycle past each leading acknowledged slot
        if (marks[0] && cnt_r != '0) begin
          ctl.shift = 1'b1;
          cnt_nxt   = cnt_r - CNT_W'(1);
          base_nxt  = base_r + srsw_pkg::SEQ_W'(1);
        end else if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (out_free) begin
          load      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // chain of mark cells, slot 0 at the base
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == WINDOW - 1) begin : g_last
      assign right_w[i] = 1'b0;
    end else begin : g_mid
      assign right_w[i] = marks[i+1];
    end
    srsw_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .idx        (ctl_idx),
      .right_mark (right_w[i]),
      .mark       (marks[i])
    );
  end

  // state, window registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      base_r      <= srsw_pkg::SEQ_RESET;
      next_r      <= srsw_pkg::SEQ_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      base_r  <= base_nxt;
      next_r  <= next_nxt;
      cnt_r   <= cnt_nxt;
      pend_r  <= pend_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
        out_res_r   <= load_res;
        out_full_r  <= (cnt_nxt >= CNT_W'(WINDOW));
        out_base_r  <= base_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result ports
  assign out_valid         = out_valid_r;
  assign out_send_accepted = out_res_r.send_accepted;
  assign out_transmit      = out_res_r.transmit;
  assign out_transmit_seq  = out_res_r.transmit_seq;
  assign out_start_timer   = out_res_r.start_timer;
  assign out_stop_timer    = out_res_r.stop_timer;
  assign out_timer_seq     = out_res_r.timer_seq;
  assign out_window_full   = out_full_r;
  assign out_window_base   = out_base_r;

endmodule

FILE: hdl/srsw_checker.sv
// port-level checks for selective_repeat_sender_window
// depends on srsw_pkg for widths; bound to the top level below
module srsw_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic [1:0]                  in_operation,
  input logic [srsw_pkg::SEQ_W-1:0]  in_seq_number,
  input logic                        in_checksum_ok,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_send_accepted,
  input logic                        out_transmit,
  input logic [srsw_pkg::SEQ_W-1:0]  out_transmit_seq,
  input logic                        out_start_timer,
  input logic                        out_stop_timer,
  input logic [srsw_pkg::SEQ_W-1:0]  out_timer_seq,
  input logic                        out_window_full,
  input logic [srsw_pkg::SEQ_W-1:0]  out_window_base
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an accepted send transmits and starts the timer of the same sequence
  a_send_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_send_accepted |->
      out_transmit && out_start_timer && !out_stop_timer &&
      out_transmit_seq == out_timer_seq)
    else $error("accepted send without matching transmit and timer start");

  // a timer is never started and stopped by the same transfer
  a_timer_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_start_timer && out_stop_timer))
    else $error("timer started and stopped together");

  // idle sequence fields read zero
  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_transmit && !out_start_timer && !out_stop_timer |->
      out_transmit_seq == '0 && out_timer_seq == '0)
    else $error("sequence field set without an action");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_window_base) &&
      $stable(out_timer_seq))
    else $error("stalled result changed");

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (.*);

FILE: tb/srsw_report_checker.sv
// result checker for the selective-repeat sender window: predicts each result and compares
// depends on srsw_pkg; instantiated by tb_top beside the block, watches both channels
module srsw_report_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [1:0]                  in_operation,
  input  logic [srsw_pkg::SEQ_W-1:0]  in_seq_number,
  input  logic                        in_checksum_ok,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        out_send_accepted,
  input  logic                        out_transmit,
  input  logic [srsw_pkg::SEQ_W-1:0]  out_transmit_seq,
  input  logic                        out_start_timer,
  input  logic                        out_stop_timer,
  input  logic [srsw_pkg::SEQ_W-1:0]  out_timer_seq,
  input  logic                        out_window_full,
  input  logic [srsw_pkg::SEQ_W-1:0]  out_window_base,
  output int                          mismatch_count,
  output int                          reports_owed
);

  localparam int WIN = 4;
  localparam int SHOWN_MISMATCHES = 10;
  localparam int OWED_DEPTH = 8;

  typedef struct packed {
    logic                       send_accepted;
    logic                       transmit;
    logic [srsw_pkg::SEQ_W-1:0] transmit_seq;
    logic                       start_timer;
    logic                       stop_timer;
    logic [srsw_pkg::SEQ_W-1:0] timer_seq;
    logic                       window_full;
    logic [srsw_pkg::SEQ_W-1:0] window_base;
  } window_report_t;

  // predicted window state
  logic [srsw_pkg::SEQ_W-1:0] base_seq_m;
  logic [srsw_pkg::SEQ_W-1:0] next_seq_m;
  int unsigned                in_flight;
  logic [WIN-1:0]             ack_marks;

  // predicted results waiting for their transfer, oldest at owed_rd
  window_report_t             owed_fifo [OWED_DEPTH];
  int                         owed_wr;
  int                         owed_rd;
  int                         owed_num;
  window_report_t             want_report;
  window_report_t             got_report;
  int                         mismatches = 0;

  // one event through the window; updates the predicted state
  function automatic window_report_t advance_window(logic [1:0] op,
                                                    logic [srsw_pkg::SEQ_W-1:0] seq,
                                                    logic ok);
    window_report_t r;
    logic [srsw_pkg::SEQ_W-1:0] off;
    int unsigned lead;
    r = '0;
    off = seq - base_seq_m;
    case (op)
      srsw_pkg::OP_SEND: if (in_flight < WIN) begin
        r.send_accepted = 1'b1;
        r.transmit      = 1'b1;
        r.transmit_seq  = next_seq_m;
        r.start_timer   = 1'b1;
        r.timer_seq     = next_seq_m;
        ack_marks[in_flight] = 1'b0;
        in_flight++;
        next_seq_m++;
      end
      srsw_pkg::OP_ACK: if (ok && off < in_flight) begin
        r.stop_timer = 1'b1;
        r.timer_seq  = seq;
        ack_marks[off] = 1'b1;
        // an ack at the base slides past every leading marked slot
        if (off == 0) begin
          lead = 0;
          while (lead < in_flight && ack_marks[lead]) lead++;
          ack_marks  = ack_marks >> lead;
          in_flight  = in_flight - lead;
          base_seq_m = base_seq_m + srsw_pkg::SEQ_W'(lead);
        end
      end
      srsw_pkg::OP_TIMEOUT: if (off < in_flight && !ack_marks[off]) begin
        r.transmit     = 1'b1;
        r.transmit_seq = seq;
        r.start_timer  = 1'b1;
        r.timer_seq    = seq;
      end
      default: ;
    endcase
    r.window_full = (in_flight >= WIN);
    r.window_base = base_seq_m;
    return r;
  endfunction

  function automatic string report_text(window_report_t r);
    return $sformatf("acc=%0d tx=%0d tx_seq=%0d start=%0d stop=%0d t_seq=%0d full=%0d base=%0d",
                     r.send_accepted, r.transmit, r.transmit_seq, r.start_timer,
                     r.stop_timer, r.timer_seq, r.window_full, r.window_base);
  endfunction

  // predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    if (!rst_n) begin
      base_seq_m = srsw_pkg::SEQ_RESET;
      next_seq_m = srsw_pkg::SEQ_RESET;
      in_flight  = 0;
      ack_marks  = '0;
      owed_wr    = 0;
      owed_rd    = 0;
      owed_num   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        owed_fifo[owed_wr] = advance_window(in_operation, in_seq_number, in_checksum_ok);
        owed_wr  = (owed_wr + 1) % OWED_DEPTH;
        owed_num++;
      end
      if (out_valid && !out_stall) begin
        got_report = '{out_send_accepted, out_transmit, out_transmit_seq, out_start_timer,
                       out_stop_timer, out_timer_seq, out_window_full, out_window_base};
        if (owed_num == 0) begin
          mismatches++;
          if (mismatches <= SHOWN_MISMATCHES)
            $display("unexpected result: %s", report_text(got_report));
        end else begin
          want_report = owed_fifo[owed_rd];
          owed_rd  = (owed_rd + 1) % OWED_DEPTH;
          owed_num--;
          if (got_report !== want_report) begin
            mismatches++;
            if (mismatches <= SHOWN_MISMATCHES)
              $display("mismatch: expected %s, actual %s",
                       report_text(want_report), report_text(got_report));
          end
        end
      end
    end
    mismatch_count <= mismatches;
    reports_owed   <= owed_num;
  end

endmodule

FILE: tb/tb_top.sv
// testbench top for selective_repeat_sender_window: clock, reset, stimulus and verdict
// depends on srsw_pkg, the block and srsw_report_checker
module tb_top;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int DIRECTED_ITEMS = 26;
  localparam int RANDOM_ITEMS   = 830;
  localparam int TOTAL_ITEMS    = DIRECTED_ITEMS + RANDOM_ITEMS;
  localparam int QUIET_ITEMS    = 150;
  localparam int LONG_HOLD      = 60;
  localparam int HOLD_AT_ITEM   = 300;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 10;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic [1:0]                 in_operation = srsw_pkg::OP_SEND;
  logic [srsw_pkg::SEQ_W-1:0] in_seq_number = '0;
  logic                       in_checksum_ok = 1'b0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic                       out_send_accepted;
  logic                       out_transmit;
  logic [srsw_pkg::SEQ_W-1:0] out_transmit_seq;
  logic                       out_start_timer;
  logic                       out_stop_timer;
  logic [srsw_pkg::SEQ_W-1:0] out_timer_seq;
  logic                       out_window_full;
  logic [srsw_pkg::SEQ_W-1:0] out_window_base;

  int                         mismatch_count;
  int                         reports_owed;
  int                         items_taken = 0;
  int                         quiet_cycles = 0;
  int                         stall_left = 0;
  bit                         long_hold_done = 1'b0;
  logic [srsw_pkg::SEQ_W-1:0] seen_base = srsw_pkg::SEQ_RESET;

  logic [1:0]                 op_pick;
  logic [srsw_pkg::SEQ_W-1:0] seq_pick;
  logic [srsw_pkg::SEQ_W-1:0] ack_seq;
  int                         pick;

  always #2 clk = ~clk;

  selective_repeat_sender_window u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_seq_number     (in_seq_number),
    .in_checksum_ok    (in_checksum_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_accepted (out_send_accepted),
    .out_transmit      (out_transmit),
    .out_transmit_seq  (out_transmit_seq),
    .out_start_timer   (out_start_timer),
    .out_stop_timer    (out_stop_timer),
    .out_timer_seq     (out_timer_seq),
    .out_window_full   (out_window_full),
    .out_window_base   (out_window_base)
  );

  srsw_report_checker u_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_seq_number     (in_seq_number),
    .in_checksum_ok    (in_checksum_ok),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_accepted (out_send_accepted),
    .out_transmit      (out_transmit),
    .out_transmit_seq  (out_transmit_seq),
    .out_start_timer   (out_start_timer),
    .out_stop_timer    (out_stop_timer),
    .out_timer_seq     (out_timer_seq),
    .out_window_full   (out_window_full),
    .out_window_base   (out_window_base),
    .mismatch_count    (mismatch_count),
    .reports_owed      (reports_owed)
  );

  // idle bursts run in phases, none in the last part of the run
  function automatic bit idling_allowed();
    return items_taken < TOTAL_ITEMS - QUIET_ITEMS && (items_taken / 80) % 3 != 2;
  endfunction

  // count input transfers and track the window base as reported
  always @(posedge clk) begin
    if (in_valid && !in_stall) items_taken <= items_taken + 1;
    if (out_valid && !out_stall) seen_base <= out_window_base;
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[selective_repeat_sender_window] ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // result side: short random stalls plus one long hold-off to fill the block
  initial begin
    forever begin
      @(negedge clk);
      if (!long_hold_done && items_taken >= HOLD_AT_ITEM) begin
        long_hold_done = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && idling_allowed() && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      out_stall <= (stall_left > 0);
      if (stall_left > 0) stall_left--;
    end
  end

  // one event transfer, with an optional idle burst ahead of it
  task automatic offer_event(logic [1:0] op, logic [srsw_pkg::SEQ_W-1:0] seq, logic ok);
    if (idling_allowed() && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_seq_number  <= seq;
    in_checksum_ok <= ok;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty window: unused code, stray timeout, stray ack
    offer_event(OP_UNUSED, 3'd7, 1'b1);
    offer_event(srsw_pkg::OP_TIMEOUT, 3'd1, 1'b1);
    offer_event(srsw_pkg::OP_ACK, 3'd1, 1'b1);
    // fill the window, then one refused send
    repeat (5) offer_event(srsw_pkg::OP_SEND, 3'd0, 1'b0);
    // bad checksum, ack off the base, repeated ack
    offer_event(srsw_pkg::OP_ACK, 3'd3, 1'b0);
    offer_event(srsw_pkg::OP_ACK, 3'd3, 1'b1);
    offer_event(srsw_pkg::OP_ACK, 3'd3, 1'b1);
    // expiry of an acked slot, a live slot, and one outside the window
    offer_event(srsw_pkg::OP_TIMEOUT, 3'd3, 1'b0);
    offer_event(srsw_pkg::OP_TIMEOUT, 3'd2, 1'b1);
    offer_event(srsw_pkg::OP_TIMEOUT, 3'd6, 1'b1);
    offer_event(srsw_pkg::OP_ACK, 3'd0, 1'b1);
    // ack the base, sliding three slots
    offer_event(srsw_pkg::OP_ACK, 3'd2, 1'b1);
    offer_event(srsw_pkg::OP_ACK, 3'd1, 1'b1);
    repeat (4) offer_event(srsw_pkg::OP_SEND, 3'd7, 1'b1);
    // acks in reverse order, full slide across the wrap
    for (int s = 7; s >= 4; s--) offer_event(srsw_pkg::OP_ACK, srsw_pkg::SEQ_W'(s), 1'b1);
    offer_event(srsw_pkg::OP_SEND, 3'd7, 1'b1);

    // random events, acks and timeouts mostly near the current base
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick     = $urandom_range(0, 99);
      ack_seq  = seen_base + srsw_pkg::SEQ_W'($urandom_range(0, 3));
      seq_pick = ($urandom_range(0, 4) < 3) ? ack_seq : srsw_pkg::SEQ_W'($urandom);
      if (pick < 35)      op_pick = srsw_pkg::OP_SEND;
      else if (pick < 75) op_pick = srsw_pkg::OP_ACK;
      else if (pick < 93) op_pick = srsw_pkg::OP_TIMEOUT;
      else                op_pick = OP_UNUSED;
      offer_event(op_pick, seq_pick, $urandom_range(0, 9) != 0);
    end
    in_valid <= 1'b0;

    // drain and settle
    while (reports_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[selective_repeat_sender_window] OK");
    end else begin
      $display("[selective_repeat_sender_window] ERROR");
    end
    $finish;
  end

endmodule
